### hdl/lpcibp_pkg.sv
`timescale 1ns / 1ps

package lpcibp_pkg;

  // longest unary run before the frame is aborted
  localparam int MAX_QN = 36;
  // largest qn value the syntax can produce
  localparam int QN_MAX = MAX_QN + 4;
  localparam int QN_W = $clog2(QN_MAX + 1);
  // widest extension index
  localparam int NK_MAX = (QN_MAX - 3) / 2;
  localparam int FIELD_MAX = (NK_MAX > 16) ? NK_MAX : 16;
  localparam int REM_W = $clog2(FIELD_MAX + 1);

  localparam int IQ_DEPTH = 2;
  localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

  // set positions in parse order
  localparam logic [2:0] POS_A = 3'd0;
  localparam logic [2:0] POS_B = 3'd1;
  localparam logic [2:0] POS_C = 3'd2;
  localparam logic [2:0] POS_D = 3'd3;
  localparam logic [2:0] POS_E = 3'd4;
  localparam logic [2:0] POS_END = 3'd5;

  typedef struct packed {
    logic       bit_value;
    logic       frame_start;
    logic       first_frame;
    logic [1:0] mode_first;
    logic [1:0] mode_third;
  } in_item_t;

  typedef struct packed {
    logic [15:0] index_value;
    logic [6:0]  slot;
    logic        frame_done;
    logic        parse_error;
  } out_item_t;

  // classified bit: set_en[i] enables set position i+1
  typedef struct packed {
    logic       bit_value;
    logic       frame_start;
    logic [3:0] set_en;
  } cmd_t;

  function automatic logic [REM_W-1:0] ext_width(input logic [QN_W-1:0] q);
    logic [QN_W-1:0] d;
    d = q - QN_W'(3);
    if (q > QN_W'(4)) begin
      return REM_W'(d >> 1);
    end
    return '0;
  endfunction

endpackage

### hdl/lpcibp_front.sv
`timescale 1ns / 1ps

module lpcibp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  lpcibp_pkg::in_item_t item,
  output logic                 cmd_valid,
  output lpcibp_pkg::cmd_t     cmd,
  input  logic                 take
);

  lpcibp_pkg::cmd_t              slots [lpcibp_pkg::IQ_DEPTH];
  logic [lpcibp_pkg::IQ_PTR_W-1:0] wr_ptr;
  logic [lpcibp_pkg::IQ_PTR_W-1:0] rd_ptr;
  logic [lpcibp_pkg::IQ_PTR_W:0]   count;
  lpcibp_pkg::cmd_t              entry;
  logic                          wr_en;
  logic                          rd_en;

  // set enables decoded from first_frame and the frame modes
  always_comb begin
    entry.bit_value   = item.bit_value;
    entry.frame_start = item.frame_start;
    entry.set_en[0]   = item.first_frame;
    entry.set_en[1]   = (item.mode_first != 2'd3);
    entry.set_en[2]   = !item.mode_first[1];
    entry.set_en[3]   = !item.mode_third[1];
  end

  assign full      = (count == (lpcibp_pkg::IQ_PTR_W+1)'(lpcibp_pkg::IQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = slots[rd_ptr];
  assign wr_en     = push && !full;
  assign rd_en     = take && cmd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/lpcibp_outq.sv
`timescale 1ns / 1ps

module lpcibp_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  input  lpcibp_pkg::out_item_t wr_data,
  output logic                  full,
  output logic                  empty,
  input  logic                  rd,
  output lpcibp_pkg::out_item_t rd_data
);

  lpcibp_pkg::out_item_t           slots [lpcibp_pkg::OQ_DEPTH];
  logic [lpcibp_pkg::OQ_PTR_W-1:0] wr_ptr;
  logic [lpcibp_pkg::OQ_PTR_W-1:0] rd_ptr;
  logic [lpcibp_pkg::OQ_PTR_W:0]   count;
  logic                            wr_en;
  logic                            rd_en;

  assign full    = (count == (lpcibp_pkg::OQ_PTR_W+1)'(lpcibp_pkg::OQ_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];
  assign wr_en   = wr && !full;
  assign rd_en   = rd && !empty;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/lpcibp_engine.sv
`timescale 1ns / 1ps

module lpcibp_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  lpcibp_pkg::cmd_t      cmd,
  output logic                  take,
  output logic                  res_push,
  output lpcibp_pkg::out_item_t res_data,
  input  logic                  res_full
);

  typedef enum logic [11:0] {
    PH_IDLE    = 12'b000000000001,
    PH_FIRST8  = 12'b000000000010,
    PH_MODE    = 12'b000000000100,
    PH_ABS8    = 12'b000000001000,
    PH_QN2     = 12'b000000010000,
    PH_QNU     = 12'b000000100000,
    PH_QNX     = 12'b000001000000,
    PH_BASE    = 12'b000010000000,
    PH_EXT     = 12'b000100000000,
    PH_QNOUT0  = 12'b001000000000,
    PH_QNOUT1  = 12'b010000000000,
    PH_EXTLOOP = 12'b100000000000
  } phase_t;

  phase_t                           phase, phase_next;
  logic [2:0]                       set_pos, set_pos_next;
  logic [1:0]                       cbm, cbm_next;
  logic [lpcibp_pkg::QN_W-1:0]      qn0, qn0_next;
  logic [lpcibp_pkg::QN_W-1:0]      qn1, qn1_next;
  logic [1:0]                       qidx, qidx_next;
  logic [15:0]                      acc, acc_next;
  logic [lpcibp_pkg::REM_W-1:0]     rem, rem_next;
  logic [3:0]                       ext_cnt, ext_cnt_next;
  logic [6:0]                       wp, wp_next;
  logic [3:0]                       set_en, set_en_next;
  logic [1:0]                       mode_val, mode_val_next;
  logic                             mark, mark_next;
  lpcibp_pkg::out_item_t            hold, hold_next;
  logic                             hold_valid, hold_valid_next;

  function automatic logic [2:0] seek(input logic [2:0] s, input logic [3:0] en);
    logic [2:0] r;
    r = lpcibp_pkg::POS_END;
    for (int p = 4; p >= 1; p--) begin
      if ((3'(p) >= s) && en[p-1]) begin
        r = 3'(p);
      end
    end
    return r;
  endfunction

  always_comb begin
    logic                          b;
    logic                          fin;
    logic [1:0]                    fm;
    logic                          go_abs;
    logic                          go_cb;
    logic                          go_cbegin;
    logic                          go_set;
    logic                          go_scan;
    logic                          go_ext;
    logic                          frame_end;
    logic                          do_emit;
    logic [1:0]                    qi;
    logic [lpcibp_pkg::QN_W-1:0]   q;
    logic [15:0]                   ev;
    logic                          edone;
    logic                          eerr;
    logic [lpcibp_pkg::REM_W-1:0]  w;
    logic [2:0]                    n;
    logic [2:0]                    npos;

    phase_next      = phase;
    set_pos_next    = set_pos;
    cbm_next        = cbm;
    qn0_next        = qn0;
    qn1_next        = qn1;
    qidx_next       = qidx;
    acc_next        = acc;
    rem_next        = rem;
    ext_cnt_next    = ext_cnt;
    wp_next         = wp;
    set_en_next     = set_en;
    mode_val_next   = mode_val;
    mark_next       = mark;
    hold_next       = hold;
    hold_valid_next = hold_valid;

    take      = 1'b0;
    res_push  = 1'b0;
    res_data  = hold;
    res_data.frame_done = hold.frame_done | mark;

    b = cmd.bit_value;
    fin = 1'b0;
    fm = 2'd0;
    go_abs = 1'b0;
    go_cb = 1'b0;
    go_cbegin = 1'b0;
    go_set = 1'b0;
    go_scan = 1'b0;
    go_ext = 1'b0;
    frame_end = 1'b0;
    do_emit = 1'b0;
    qi = 2'd0;
    q = '0;
    ev = 16'd0;
    edone = 1'b0;
    eerr = 1'b0;
    w = '0;
    n = 3'd0;
    npos = 3'd0;

    if (!res_full) begin
      if ((phase != PH_QNOUT0) && (phase != PH_QNOUT1) && (phase != PH_EXTLOOP)) begin
        // step boundary: the held result is the last of its step
        if (hold_valid) begin
          res_push        = 1'b1;
          hold_valid_next = 1'b0;
          mark_next       = 1'b0;
        end
        if (cmd_valid) begin
          take = 1'b1;
          if (cmd.frame_start) begin
            set_en_next  = cmd.set_en;
            wp_next      = 7'd0;
            cbm_next     = 2'd0;
            set_pos_next = lpcibp_pkg::POS_A;
            ext_cnt_next = 4'd0;
            phase_next   = PH_FIRST8;
            acc_next     = 16'd0;
            rem_next     = lpcibp_pkg::REM_W'(8);
          end
          case (phase_next)
            PH_MODE: begin
              case (set_pos_next)
                lpcibp_pkg::POS_B, lpcibp_pkg::POS_C: begin
                  if (b) begin
                    cbm_next = 2'd3;
                  end
                  fin = 1'b1;
                  fm  = {1'b0, b};
                end
                lpcibp_pkg::POS_D: begin
                  if (rem_next == '0) begin
                    if (!b) begin
                      cbm_next = 2'd2;
                      fin = 1'b1;
                      fm = 2'd2;
                    end else begin
                      rem_next = lpcibp_pkg::REM_W'(1);
                    end
                  end else begin
                    cbm_next = {1'b0, b};
                    fin = 1'b1;
                    fm = {1'b0, b};
                  end
                end
                default: begin
                  if (rem_next == '0) begin
                    if (!b) begin
                      cbm_next = 2'd1;
                      fin = 1'b1;
                      fm = 2'd1;
                    end else begin
                      rem_next = lpcibp_pkg::REM_W'(1);
                    end
                  end else if (rem_next == lpcibp_pkg::REM_W'(1)) begin
                    if (!b) begin
                      cbm_next = 2'd0;
                      fin = 1'b1;
                      fm = 2'd0;
                    end else begin
                      rem_next = lpcibp_pkg::REM_W'(2);
                    end
                  end else begin
                    cbm_next = 2'd2;
                    fin = 1'b1;
                    fm = {1'b1, b};
                  end
                end
              endcase
              if (fin) begin
                mode_val_next = fm;
                do_emit = 1'b1;
                ev = {14'd0, fm};
                if (fm == 2'd0) begin
                  phase_next = PH_ABS8;
                  acc_next   = 16'd0;
                  rem_next   = lpcibp_pkg::REM_W'(8);
                end else begin
                  go_abs = 1'b1;
                end
              end
            end
            PH_QNU, PH_QNX: begin
              if (b) begin
                acc_next = acc_next + 16'd1;
                if (acc_next > 16'(lpcibp_pkg::MAX_QN)) begin
                  do_emit    = 1'b1;
                  ev         = 16'd0;
                  edone      = 1'b1;
                  eerr       = 1'b1;
                  phase_next = PH_IDLE;
                end
              end else begin
                if (phase_next == PH_QNU) begin
                  q = (acc_next != 16'd0) ?
                      lpcibp_pkg::QN_W'(acc_next) + lpcibp_pkg::QN_W'(1) : '0;
                end else if (cbm_next == 2'd2) begin
                  q = (acc_next != 16'd0) ?
                      lpcibp_pkg::QN_W'(acc_next) + lpcibp_pkg::QN_W'(4) : '0;
                end else begin
                  case (acc_next)
                    16'd0:   q = lpcibp_pkg::QN_W'(5);
                    16'd1:   q = lpcibp_pkg::QN_W'(6);
                    16'd2:   q = '0;
                    default: q = lpcibp_pkg::QN_W'(acc_next) + lpcibp_pkg::QN_W'(4);
                  endcase
                end
                if (qidx_next[0]) begin
                  qn1_next = q;
                end else begin
                  qn0_next = q;
                end
                qidx_next = qidx_next + 2'd1;
                acc_next  = 16'd0;
                if (phase_next == PH_QNU) begin
                  if (qidx_next == 2'd2) begin
                    phase_next = PH_QNOUT0;
                  end
                end else begin
                  go_scan = 1'b1;
                end
              end
            end
            PH_FIRST8, PH_ABS8, PH_QN2, PH_BASE, PH_EXT: begin
              acc_next = {acc_next[14:0], b};
              if (rem_next != '0) begin
                rem_next = rem_next - lpcibp_pkg::REM_W'(1);
              end
              if (rem_next == '0) begin
                case (phase_next)
                  PH_FIRST8: begin
                    do_emit = 1'b1;
                    ev = acc_next;
                    go_cbegin = 1'b1;
                  end
                  PH_ABS8: begin
                    do_emit = 1'b1;
                    ev = acc_next;
                    go_abs = 1'b1;
                  end
                  PH_QN2: begin
                    qn0_next  = lpcibp_pkg::QN_W'(acc_next[3:2]) + lpcibp_pkg::QN_W'(2);
                    qn1_next  = lpcibp_pkg::QN_W'(acc_next[1:0]) + lpcibp_pkg::QN_W'(2);
                    qidx_next = 2'd0;
                    go_scan   = 1'b1;
                  end
                  PH_BASE: begin
                    do_emit = 1'b1;
                    ev = acc_next;
                    ext_cnt_next = 4'd0;
                    go_ext = 1'b1;
                  end
                  default: begin
                    do_emit = 1'b1;
                    ev = acc_next;
                    ext_cnt_next = ext_cnt_next + 4'd1;
                    go_ext = 1'b1;
                  end
                endcase
              end
            end
            default: begin
            end
          endcase
        end
      end else begin
        case (phase)
          PH_QNOUT0: begin
            do_emit    = 1'b1;
            ev         = 16'(qn0);
            phase_next = PH_QNOUT1;
          end
          PH_QNOUT1: begin
            do_emit   = 1'b1;
            ev        = 16'(qn1);
            qidx_next = 2'd0;
            go_cb     = 1'b1;
            qi        = 2'd0;
          end
          default: begin
            // zero-width extensions, one per cycle while the result queue has room
            if (ext_cnt < 4'd8) begin
              do_emit      = 1'b1;
              ev           = 16'd0;
              ext_cnt_next = ext_cnt + 4'd1;
            end else begin
              qidx_next = qidx + 2'd1;
              go_cb     = 1'b1;
              qi        = qidx + 2'd1;
            end
          end
        endcase
      end
    end

    // scan for a qn that needs an extension run
    if (go_scan) begin
      if ((qidx_next == 2'd0) && (qn0_next > lpcibp_pkg::QN_W'(4))) begin
        qidx_next = 2'd0;
        phase_next = PH_QNX;
        acc_next = 16'd0;
      end else if ((qidx_next != 2'd2) && (qn1_next > lpcibp_pkg::QN_W'(4))) begin
        qidx_next = 2'd1;
        phase_next = PH_QNX;
        acc_next = 16'd0;
      end else begin
        phase_next = PH_QNOUT0;
      end
    end

    if (go_ext) begin
      w = lpcibp_pkg::ext_width(qidx_next[0] ? qn1_next : qn0_next);
      if ((ext_cnt_next < 4'd8) && (w != '0)) begin
        phase_next = PH_EXT;
        rem_next   = w;
        acc_next   = 16'd0;
      end else begin
        phase_next = PH_EXTLOOP;
      end
    end

    if (go_abs) begin
      if ((set_pos_next == lpcibp_pkg::POS_D) && (mode_val_next == 2'd1)) begin
        set_pos_next = set_pos_next + 3'd1;
        go_set = 1'b1;
      end else begin
        go_cbegin = 1'b1;
      end
    end

    // next codebook with a nonzero qn
    if (go_cb) begin
      if ((qi == 2'd0) && (qn0_next != '0)) begin
        qidx_next = 2'd0;
        q = qn0_next;
      end else if ((qi != 2'd2) && (qn1_next != '0)) begin
        qidx_next = 2'd1;
        q = qn1_next;
      end else begin
        q = '0;
      end
      if (q == '0) begin
        set_pos_next = set_pos_next + 3'd1;
        go_set = 1'b1;
      end else begin
        if (q > lpcibp_pkg::QN_W'(4)) begin
          n = q[0] ? 3'd3 : 3'd4;
        end else begin
          n = q[2:0];
        end
        phase_next = PH_BASE;
        rem_next   = lpcibp_pkg::REM_W'({n, 2'b00});
        acc_next   = 16'd0;
      end
    end

    if (go_cbegin) begin
      qn0_next  = '0;
      qn1_next  = '0;
      qidx_next = 2'd0;
      acc_next  = 16'd0;
      if (cbm_next == 2'd1) begin
        phase_next = PH_QNU;
      end else begin
        phase_next = PH_QN2;
        rem_next   = lpcibp_pkg::REM_W'(4);
      end
    end

    if (go_set) begin
      npos = seek(set_pos_next, set_en_next);
      set_pos_next = npos;
      if (npos == lpcibp_pkg::POS_END) begin
        phase_next = PH_IDLE;
        frame_end  = 1'b1;
      end else begin
        phase_next = PH_MODE;
        acc_next   = 16'd0;
        rem_next   = '0;
      end
    end

    if (do_emit) begin
      if (hold_valid && !res_push) begin
        res_push = 1'b1;
      end
      hold_next.index_value = ev;
      hold_next.slot        = wp_next;
      hold_next.frame_done  = edone;
      hold_next.parse_error = eerr;
      hold_valid_next       = 1'b1;
      wp_next               = wp_next + 7'd1;
    end

    if (frame_end) begin
      mark_next = hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    hold <= hold_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      set_pos    <= '0;
      cbm        <= '0;
      qn0        <= '0;
      qn1        <= '0;
      qidx       <= '0;
      acc        <= '0;
      rem        <= '0;
      ext_cnt    <= '0;
      wp         <= '0;
      set_en     <= '0;
      mode_val   <= '0;
      mark       <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      phase      <= phase_next;
      set_pos    <= set_pos_next;
      cbm        <= cbm_next;
      qn0        <= qn0_next;
      qn1        <= qn1_next;
      qidx       <= qidx_next;
      acc        <= acc_next;
      rem        <= rem_next;
      ext_cnt    <= ext_cnt_next;
      wp         <= wp_next;
      set_en     <= set_en_next;
      mode_val   <= mode_val_next;
      mark       <= mark_next;
      hold_valid <= hold_valid_next;
    end
  end

endmodule

### hdl/lpc_index_bit_parser.sv
`timescale 1ns / 1ps

// lpc quantizer index parser, one bitstream bit per transaction
// input channel: push/full queue; each transaction carries one bit, and the
//   first bit of a frame also carries frame_start, first_frame and the two
//   quarter-frame modes
// result channel: empty/pop queue; each transaction is one parsed value
//   with its slot in the frame's index list, frame_done on the last value
//   and parse_error when a unary run is too long (the frame ends there)
// throughput: one bit per cycle while each bit yields at most one value and
//   the result queue has room; a bit that closes a qn pair holds the parser
//   while the pair goes out one value per cycle, a base index with zero-width
//   extensions holds it while the base and eight zeros go out and it moves on,
//   and the last wide extension of a codebook passes through the extension
//   loop state; the 2-entry bit queue covers short gaps, longer bursts raise full
// result path: a value is registered in the engine's hold register, then
//   written into the result queue that drives the result ports; later values
//   of a burst follow one per cycle while the result queue has room
// reset: both queues empty, parser idle; bits before a frame start are dropped
// stall: when the result queue fills the parser freezes, the bit queue then
//   fills and full rises; nothing is lost
module lpc_index_bit_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  lpcibp_pkg::in_item_t  item,
  output logic                  empty,
  input  logic                  pop,
  output lpcibp_pkg::out_item_t result
);

  logic                  cmd_valid;
  lpcibp_pkg::cmd_t      cmd;
  logic                  take;
  logic                  res_push;
  lpcibp_pkg::out_item_t res_data;
  logic                  res_full;

  // front: bit queue and set-enable decode
  lpcibp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .take      (take)
  );

  // back: syntax state machine
  lpcibp_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .take      (take),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_full  (res_full)
  );

  // result queue
  lpcibp_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .empty   (empty),
    .rd      (pop),
    .rd_data (result)
  );

  // the parser never pushes into a full result queue
  assert property (@(posedge clk) disable iff (rst) res_push |-> !res_full)
    else $error("result pushed into full queue");

  // an aborted frame always closes the frame
  assert property (@(posedge clk) disable iff (rst)
    (!empty && result.parse_error) |-> result.frame_done)
    else $error("parse error without frame done");

  // bits are only taken when present
  assert property (@(posedge clk) disable iff (rst) take |-> cmd_valid)
    else $error("bit taken from empty queue");

  // reset leaves the result queue empty and the bit queue not full
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> (empty && !full))
    else $error("queues not empty after reset");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

// lpc index bit parser: directed table followed by frame-aware random bits,
// every result transaction checked against a behavioral predictor
module testbench;

  // parser phases of the predictor
  typedef enum int {
    PH_IDLE, PH_FIRST8, PH_MODE, PH_ABS8, PH_QN2, PH_QNU, PH_QNX, PH_BASE, PH_EXT
  } phase_e;

  // how a directed row is checked beyond the predictor
  typedef enum int {CHK_PRED, CHK_NONE, CHK_FIRST} row_chk_e;

  typedef struct {
    lpcibp_pkg::in_item_t  it;
    row_chk_e              chk;
    lpcibp_pkg::out_item_t want;
  } row_t;

  localparam int N_ITEMS   = 430;
  localparam int HOLD_CYC  = 300;   // long receiver hold-off
  localparam int QUIET_LO  = 600;   // window with no idling on either side
  localparam int QUIET_HI  = 850;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  lpcibp_pkg::in_item_t  item = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  lpcibp_pkg::out_item_t result;

  lpc_index_bit_parser dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  always #5 clk = ~clk;

  // predictor state
  phase_e     ph = PH_IDLE;
  logic [2:0] set_pos = '0;
  logic [1:0] cb_mode = '0;
  logic [5:0] qn [2] = '{default: '0};
  logic [15:0] acc = '0;
  logic [4:0] bits_left = '0;
  logic [3:0] ext_cnt = '0;
  logic [6:0] wpos = '0;
  logic       ff_en = 1'b0;
  logic [1:0] m_first = '0, m_third = '0;
  int         qi = 0;
  logic [1:0] mode_val = '0;

  lpcibp_pkg::out_item_t expected_values[$];  // values still owed by the parser
  lpcibp_pkg::out_item_t step_values[$];      // values produced by the current bit

  int errors = 0;
  int n_checked = 0;
  int n_frames = 0;
  int n_aborts = 0;
  int cyc = 0;
  bit quiet;

  always @(posedge clk) cyc <= cyc + 1;
  assign quiet = (cyc >= QUIET_LO) && (cyc < QUIET_HI);

  function automatic void put_value(logic [15:0] v, logic done, logic err);
    lpcibp_pkg::out_item_t r;
    r.index_value = v;
    r.slot = wpos;
    r.frame_done = done;
    r.parse_error = err;
    expected_values.push_back(r);
    step_values.push_back(r);
    wpos = wpos + 7'd1;
  endfunction

  function automatic void start_field(phase_e p, int w);
    ph = p;
    acc = '0;
    bits_left = 5'(w);
  endfunction

  function automatic bit set_on(logic [2:0] p);
    case (p)
      lpcibp_pkg::POS_A: return 1'b1;
      lpcibp_pkg::POS_B: return ff_en;
      lpcibp_pkg::POS_C: return m_first < 2'd3;
      lpcibp_pkg::POS_D: return m_first < 2'd2;
      lpcibp_pkg::POS_E: return m_third < 2'd2;
      default: return 1'b0;
    endcase
  endfunction

  function automatic int nk_of(logic [5:0] q);
    return (q > 6'd4) ? int'((q - 6'd3) >> 1) : 0;
  endfunction

  function automatic void next_set();
    while (set_pos < lpcibp_pkg::POS_END && !set_on(set_pos)) set_pos++;
    if (set_pos >= lpcibp_pkg::POS_END) begin
      // last value of the frame carries the done flag
      if (step_values.size() > 0) begin
        expected_values[expected_values.size() - 1].frame_done = 1'b1;
        step_values[step_values.size() - 1].frame_done = 1'b1;
      end
      ph = PH_IDLE;
      return;
    end
    if (set_pos == lpcibp_pkg::POS_A) begin
      start_field(PH_FIRST8, 8);
    end else begin
      ph = PH_MODE;
      acc = '0;
      bits_left = '0;
    end
  endfunction

  function automatic void next_codebook();
    int n;
    while (qi < 2 && qn[qi] == 0) qi++;
    if (qi >= 2) begin
      set_pos++;
      next_set();
      return;
    end
    n = (qn[qi] > 6'd4) ? int'(qn[qi]) - 2 * nk_of(qn[qi]) : int'(qn[qi]);
    start_field(PH_BASE, 4 * n);
  endfunction

  // zero-width extension reads emit without consuming a bit
  function automatic void ext_step();
    int w;
    w = nk_of(qn[qi & 1]);
    while (ext_cnt < 4'd8) begin
      if (w == 0) begin
        put_value('0, 1'b0, 1'b0);
        ext_cnt++;
      end else begin
        start_field(PH_EXT, w);
        return;
      end
    end
    qi++;
    next_codebook();
  endfunction

  function automatic void qn_pair_done();
    put_value(16'(qn[0]), 1'b0, 1'b0);
    put_value(16'(qn[1]), 1'b0, 1'b0);
    qi = 0;
    next_codebook();
  endfunction

  function automatic void scan_ext_qn();
    while (qi < 2 && qn[qi] <= 6'd4) qi++;
    if (qi >= 2) begin
      qn_pair_done();
      return;
    end
    ph = PH_QNX;
    acc = '0;
  endfunction

  function automatic void open_codebook();
    qn[0] = '0;
    qn[1] = '0;
    qi = 0;
    if (cb_mode == 2'd1) begin
      ph = PH_QNU;
      acc = '0;
    end else begin
      start_field(PH_QN2, 4);
    end
  endfunction

  function automatic void after_abs_index();
    // set D with mode code 1 carries no codebook group
    if (set_pos == lpcibp_pkg::POS_D && mode_val == 2'd1) begin
      set_pos++;
      next_set();
    end else begin
      open_codebook();
    end
  endfunction

  function automatic void mode_known(logic [1:0] m);
    mode_val = m;
    put_value(16'(m), 1'b0, 1'b0);
    if (m == 2'd0) start_field(PH_ABS8, 8);
    else after_abs_index();
  endfunction

  function automatic void take_mode_bit(logic b);
    if (set_pos == lpcibp_pkg::POS_B || set_pos == lpcibp_pkg::POS_C) begin
      if (b) cb_mode = 2'd3;
      mode_known({1'b0, b});
    end else if (set_pos == lpcibp_pkg::POS_D) begin
      if (bits_left == 0) begin
        if (!b) begin
          cb_mode = 2'd2;
          mode_known(2'd2);
        end else bits_left = 5'd1;
      end else begin
        cb_mode = {1'b0, b};
        mode_known({1'b0, b});
      end
    end else begin
      if (bits_left == 0) begin
        if (!b) begin
          cb_mode = 2'd1;
          mode_known(2'd1);
        end else bits_left = 5'd1;
      end else if (bits_left == 1) begin
        if (!b) begin
          cb_mode = 2'd0;
          mode_known(2'd0);
        end else bits_left = 5'd2;
      end else begin
        cb_mode = 2'd2;
        mode_known({1'b1, b});
      end
    end
  endfunction

  function automatic void field_complete();
    logic [15:0] v;
    v = acc;
    case (ph)
      PH_FIRST8: begin
        put_value(v, 1'b0, 1'b0);
        open_codebook();
      end
      PH_ABS8: begin
        put_value(v, 1'b0, 1'b0);
        after_abs_index();
      end
      PH_QN2: begin
        qn[0] = 6'd2 + 6'(v[3:2]);
        qn[1] = 6'd2 + 6'(v[1:0]);
        qi = 0;
        scan_ext_qn();
      end
      PH_BASE: begin
        put_value(v, 1'b0, 1'b0);
        ext_cnt = '0;
        ext_step();
      end
      PH_EXT: begin
        put_value(v, 1'b0, 1'b0);
        ext_cnt++;
        ext_step();
      end
      default: ph = PH_IDLE;
    endcase
  endfunction

  // unary run too long: one error value, frame aborted
  function automatic void unary_abort();
    put_value('0, 1'b1, 1'b1);
    ph = PH_IDLE;
    n_aborts++;
  endfunction

  function automatic void predict_bit(lpcibp_pkg::in_item_t it);
    int r;
    logic [5:0] q;
    step_values.delete();
    if (it.frame_start) begin
      ff_en = it.first_frame;
      m_first = it.mode_first;
      m_third = it.mode_third;
      wpos = '0;
      cb_mode = '0;
      set_pos = '0;
      ext_cnt = '0;
      n_frames++;
      next_set();
    end
    case (ph)
      PH_MODE: take_mode_bit(it.bit_value);
      PH_QNU, PH_QNX: begin
        if (it.bit_value) begin
          acc++;
          if (acc > 16'(lpcibp_pkg::MAX_QN)) unary_abort();
        end else begin
          r = int'(acc);
          if (ph == PH_QNU) begin
            qn[qi & 1] = (r != 0) ? 6'(r + 1) : 6'd0;
            qi++;
            acc = '0;
            if (qi >= 2) qn_pair_done();
          end else begin
            if (cb_mode == 2'd2) q = (r != 0) ? 6'(r + 4) : 6'd0;
            else if (r == 0) q = 6'd5;
            else if (r == 1) q = 6'd6;
            else if (r == 2) q = 6'd0;
            else q = 6'(r + 4);
            qn[qi & 1] = q;
            qi++;
            scan_ext_qn();
          end
        end
      end
      PH_FIRST8, PH_ABS8, PH_QN2, PH_BASE, PH_EXT: begin
        acc = {acc[14:0], it.bit_value};
        if (bits_left > 0) bits_left--;
        if (bits_left == 0) field_complete();
      end
      default: ;
    endcase
  endfunction

  function automatic lpcibp_pkg::in_item_t mk(logic b, logic fs, logic ff,
                                              logic [1:0] m0, logic [1:0] m2);
    lpcibp_pkg::in_item_t it;
    it.bit_value = b;
    it.frame_start = fs;
    it.first_frame = ff;
    it.mode_first = m0;
    it.mode_third = m2;
    return it;
  endfunction

  function automatic row_t row(lpcibp_pkg::in_item_t it, row_chk_e c, logic [15:0] v,
                               logic [6:0] s);
    row_t rw;
    rw.it = it;
    rw.chk = c;
    rw.want = '{index_value: v, slot: s, frame_done: 1'b0, parse_error: 1'b0};
    return rw;
  endfunction

  // one input transaction; the predictor runs at the accepting edge
  task automatic send_bit(lpcibp_pkg::in_item_t it);
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full !== 1'b0);
    predict_bit(it);
  endtask

  task automatic maybe_idle_input();
    if (!quiet && $urandom_range(0, 99) < 35) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  // sender: directed table, then frame-aware random bits
  initial begin
    row_t table_rows[$];
    lpcibp_pkg::in_item_t it;
    int n_sent;
    bit err_frame;
    bit in_unary;

    // ignored while idle
    table_rows.push_back(row(mk(1'b1, 1'b0, 1'b0, 2'd0, 2'd0), CHK_NONE, 16'd0, 7'd0));
    table_rows.push_back(row(mk(1'b0, 1'b0, 1'b1, 2'd3, 2'd3), CHK_NONE, 16'd0, 7'd0));
    // only set a
    table_rows.push_back(row(mk(1'b1, 1'b1, 1'b0, 2'd3, 2'd3), CHK_PRED, 16'd0, 7'd0));
    repeat (6)
      table_rows.push_back(row(mk(1'b1, 1'b0, 1'b0, 2'd0, 2'd0), CHK_NONE, 16'd0, 7'd0));
    table_rows.push_back(row(mk(1'b1, 1'b0, 1'b0, 2'd0, 2'd0), CHK_FIRST, 16'h00FF, 7'd0));
    repeat (3)
      table_rows.push_back(row(mk(1'b0, 1'b0, 1'b0, 2'd0, 2'd0), CHK_NONE, 16'd0, 7'd0));
    // qn pair 2,2
    table_rows.push_back(row(mk(1'b0, 1'b0, 1'b0, 2'd0, 2'd0), CHK_FIRST, 16'd2, 7'd1));
    // restart mid-frame with every set enabled
    table_rows.push_back(row(mk(1'b0, 1'b1, 1'b1, 2'd0, 2'd0), CHK_NONE, 16'd0, 7'd0));
    repeat (6)
      table_rows.push_back(row(mk(1'b0, 1'b0, 1'b0, 2'd0, 2'd0), CHK_NONE, 16'd0, 7'd0));
    table_rows.push_back(row(mk(1'b0, 1'b0, 1'b0, 2'd0, 2'd0), CHK_FIRST, 16'd0, 7'd0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    n_sent = 0;
    foreach (table_rows[i]) begin
      maybe_idle_input();
      send_bit(table_rows[i].it);
      n_sent++;
      if (table_rows[i].chk == CHK_NONE && step_values.size() != 0) begin
        $error("row %0d: count expected 0 actual %0d", i, step_values.size());
        errors++;
      end
      if (table_rows[i].chk == CHK_FIRST) begin
        if (step_values.size() == 0) begin
          $error("row %0d: count expected >0 actual 0", i);
          errors++;
        end else if (step_values[0] != table_rows[i].want) begin
          $error("row %0d: value expected %p actual %p", i, table_rows[i].want,
                 step_values[0]);
          errors++;
        end
      end
    end

    err_frame = 1'b0;
    while (n_sent < N_ITEMS) begin
      maybe_idle_input();
      it = mk(1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)),
              2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
      if (ph == PH_IDLE) begin
        // noise while idle, otherwise a new frame
        if ($urandom_range(0, 99) >= 15) begin
          it.frame_start = 1'b1;
          err_frame = ($urandom_range(0, 7) == 0);
          n_sent++;
        end
      end else begin
        in_unary = (ph == PH_QNU) || (ph == PH_QNX);
        if ($urandom_range(0, 99) == 0) begin
          it.frame_start = 1'b1;   // broken frame: restart mid-frame
          err_frame = 1'b0;
        end else if (in_unary) begin
          it.bit_value = err_frame ? 1'b1 : ($urandom_range(0, 99) < 35);
        end
        n_sent++;
      end
      send_bit(it);
    end
    push <= 1'b0;

    wait (expected_values.size() == 0);
    repeat (30) @(posedge clk);
    if (expected_values.size() != 0) begin
      $error("%0d expected values never arrived", expected_values.size());
      errors++;
    end
    $display("covered %0d frames, %0d unary aborts, %0d result transactions checked",
             n_frames, n_aborts, n_checked);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // receiver: random pops, one long hold-off to fill the block
  initial begin
    int hold;
    bit held_once;
    lpcibp_pkg::out_item_t exp_v;
    hold = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && empty === 1'b0) begin
        if (expected_values.size() == 0) begin
          $error("unexpected result transaction %p", result);
          errors++;
        end else begin
          exp_v = expected_values.pop_front();
          n_checked++;
          if (result.index_value !== exp_v.index_value) begin
            $error("index_value expected %0d actual %0d", exp_v.index_value,
                   result.index_value);
            errors++;
          end
          if (result.slot !== exp_v.slot) begin
            $error("slot expected %0d actual %0d", exp_v.slot, result.slot);
            errors++;
          end
          if (result.frame_done !== exp_v.frame_done) begin
            $error("frame_done expected %0d actual %0d", exp_v.frame_done,
                   result.frame_done);
            errors++;
          end
          if (result.parse_error !== exp_v.parse_error) begin
            $error("parse_error expected %0d actual %0d", exp_v.parse_error,
                   result.parse_error);
            errors++;
          end
        end
      end
      if (!held_once && n_checked >= 60) begin
        held_once = 1'b1;
        hold = HOLD_CYC;
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else begin
        pop <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 26);
      end
    end
  end

  // run limit
  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
